// ----- rtl/fat_pkg.sv -----
`timescale 1ns / 1ps

package fat_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam logic [63:0] MODEM_QUERY     = 64'h41540D41540D4154;
  localparam logic [31:0] MODEM_QUERY_LEN = 32'd8;
  localparam logic [15:0] PACKET_SIZE_RST = 16'd1024;

  // event codes
  localparam logic [1:0] OP_ARM   = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_SENT  = 2'd2;
  localparam logic [1:0] OP_RECV  = 2'd3;

  // action codes
  localparam logic [3:0] A_NONE   = 4'd0;
  localparam logic [3:0] A_HEADER = 4'd1;
  localparam logic [3:0] A_ACK    = 4'd2;
  localparam logic [3:0] A_DATA   = 4'd3;
  localparam logic [3:0] A_RECV   = 4'd4;
  localparam logic [3:0] A_SENT   = 4'd5;
  localparam logic [3:0] A_RCVD   = 4'd6;
  localparam logic [3:0] A_RESYNC = 4'd7;
  localparam logic [3:0] A_BADCMD = 4'd8;

  // configuration register indexes
  localparam logic CFG_PACKET_SIZE = 1'b0;
  localparam logic CFG_RESYNC_CMD  = 1'b1;

  typedef enum logic [2:0] {
    LK_IDLE = 3'b001,
    LK_SEND = 3'b010,
    LK_RECV = 3'b100
  } link_state_t;

  typedef enum logic [4:0] {
    SP_IDLE = 5'b00001,
    SP_INIT = 5'b00010,
    SP_FHDR = 5'b00100,
    SP_DATA = 5'b01000,
    SP_ACK  = 5'b10000
  } send_phase_t;

  typedef enum logic [4:0] {
    RP_IDLE = 5'b00001,
    RP_INIT = 5'b00010,
    RP_FHDR = 5'b00100,
    RP_DATA = 5'b01000,
    RP_ACK  = 5'b10000
  } recv_phase_t;

endpackage

// ----- rtl/fat_if.sv -----
`timescale 1ns / 1ps

interface fat_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] command;
  logic [31:0] total_length;
  logic [63:0] received_bytes;
  logic [31:0] received_length;
  logic signed [31:0] completion_code;

  modport source (
    output valid, opcode, command, total_length, received_bytes, received_length,
           completion_code,
    input  ready
  );
  modport sink (
    input  valid, opcode, command, total_length, received_bytes, received_length,
           completion_code,
    output ready
  );
endinterface

interface fat_action_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [31:0] out_command;
  logic [31:0] out_length;
  logic signed [31:0] out_code;

  modport source (
    output valid, action, out_command, out_length, out_code,
    input  ready
  );
  modport sink (
    input  valid, action, out_command, out_length, out_code,
    output ready
  );
endinterface

// ----- rtl/fragment_ack_transport_fsm_top.sv -----
`timescale 1ns / 1ps

// Fragmenting, acknowledging command transport sequencer.
// Event channel (ev): one item per transfer event (arm receive, start send,
// send completed, receive completed) with the fields that event needs.
// Action channel (act): at most one item per event, telling the data path
// to send a header, ack or data fragment, to post a receive, or reporting
// completion or an error. Events that cause nothing (the modem query, a
// completion while the matching side is idle) are taken and dropped.
// Configuration: cfg_we with cfg_index 0 sets packet_size (low 16 bits of
// cfg_data), index 1 sets resync_command. Write only while idle.
// An action is registered: it is valid in the cycle after its event is taken.
// Throughput: one event per cycle while the action register is empty or act.ready
// is high; the whole decision is a single pass through one 32-bit subtract and
// several 32-bit compares between the event port and the action register.
// Reset: all phases idle, counters zero, packet_size 1024, resync_command 0.
// Stall: ev.ready follows act.ready while an action is held, so events
// wait upstream; ready stays high while the action register is empty.
module fragment_ack_transport_fsm_top (
  input  logic        clk,
  input  logic        rst,
  fat_event_if.sink   ev,
  fat_action_if.source act,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import fat_pkg::*;

  logic [15:0] packet_size;
  logic [31:0] resync_command;

  link_state_t link_state, link_state_next;
  send_phase_t send_phase, send_phase_next;
  recv_phase_t recv_phase, recv_phase_next;
  logic [31:0] tx_command, tx_command_next;
  logic [31:0] tx_total, tx_total_next;
  logic [31:0] tx_written, tx_written_next;
  logic [31:0] rx_command, rx_command_next;
  logic [31:0] rx_total, rx_total_next;

  logic        accept;
  logic        res_valid;
  logic [3:0]  res_action;
  logic [31:0] res_command;
  logic [31:0] res_length;
  logic [31:0] res_code;

  logic [31:0] pkt32;
  logic [31:0] remaining;
  logic [31:0] frag;
  logic [31:0] hcmd;
  logic [31:0] hlen;
  logic        modem_query;

  assign ev.ready = !act.valid || act.ready;
  assign accept   = ev.valid && ev.ready;

  assign pkt32       = {16'd0, packet_size};
  assign remaining   = tx_total - tx_written;
  assign frag        = (remaining < pkt32) ? remaining : pkt32;
  assign hcmd        = ev.received_bytes[63:32];
  assign hlen        = ev.received_bytes[31:0];
  assign modem_query = (ev.received_length == MODEM_QUERY_LEN) &&
                       (ev.received_bytes == MODEM_QUERY);

  always_comb begin
    link_state_next = link_state;
    send_phase_next = send_phase;
    recv_phase_next = recv_phase;
    tx_command_next = tx_command;
    tx_total_next   = tx_total;
    tx_written_next = tx_written;
    rx_command_next = rx_command;
    rx_total_next   = rx_total;
    res_valid       = 1'b0;
    res_action      = A_NONE;
    res_command     = '0;
    res_length      = '0;
    res_code        = '0;

    if (accept) begin
      case (ev.opcode)
        OP_ARM: begin
          link_state_next = LK_RECV;
          recv_phase_next = RP_INIT;
          res_valid       = 1'b1;
          res_action      = A_RECV;
          res_length      = 32'(HEADER_BYTES);
        end
        OP_START: begin
          tx_command_next = ev.command;
          tx_total_next   = ev.total_length;
          tx_written_next = '0;
          link_state_next = LK_SEND;
          recv_phase_next = RP_IDLE;
          send_phase_next = (ev.total_length > pkt32) ? SP_INIT : SP_FHDR;
          res_valid       = 1'b1;
          res_action      = A_HEADER;
          res_command     = ev.command;
          res_length      = ev.total_length;
        end
        OP_SENT: begin
          case (send_phase)
            SP_INIT, SP_ACK: begin
              send_phase_next = SP_IDLE;
              link_state_next = LK_RECV;
              recv_phase_next = (send_phase == SP_INIT) ? RP_ACK : RP_FHDR;
              res_valid       = 1'b1;
              res_action      = A_RECV;
              res_length      = 32'(HEADER_BYTES);
            end
            SP_FHDR, SP_DATA: begin
              res_valid = 1'b1;
              if ((send_phase == SP_FHDR && tx_written == tx_total) ||
                  (send_phase == SP_DATA && tx_total <= pkt32)) begin
                // whole message out: report and forget it
                tx_command_next = '0;
                tx_total_next   = '0;
                tx_written_next = '0;
                link_state_next = LK_IDLE;
                send_phase_next = SP_IDLE;
                res_action      = A_SENT;
                res_command     = tx_command;
                res_code        = ev.completion_code;
              end else if (send_phase == SP_FHDR) begin
                link_state_next = LK_SEND;
                send_phase_next = SP_DATA;
                tx_written_next = tx_written + frag;
                res_action      = A_DATA;
                res_command     = tx_command;
                res_length      = frag;
              end else begin
                // wait for the ack of this fragment
                send_phase_next = SP_IDLE;
                link_state_next = LK_RECV;
                recv_phase_next = RP_ACK;
                res_action      = A_RECV;
                res_length      = 32'(HEADER_BYTES);
              end
            end
            default: ;
          endcase
        end
        default: begin
          if (!modem_query) begin
            case (recv_phase)
              RP_INIT, RP_FHDR: begin
                res_valid = 1'b1;
                if (recv_phase == RP_INIT) begin
                  rx_command_next = hcmd;
                  rx_total_next   = hlen;
                end
                if ((recv_phase == RP_INIT && hcmd == resync_command) ||
                    (recv_phase == RP_FHDR && hcmd != rx_command)) begin
                  send_phase_next = SP_IDLE;
                  recv_phase_next = RP_IDLE;
                  link_state_next = LK_IDLE;
                  res_action      = (recv_phase == RP_INIT) ? A_RESYNC : A_BADCMD;
                  res_command     = hcmd;
                end else if (recv_phase == RP_INIT && hlen > pkt32) begin
                  // long message: ack the first header
                  link_state_next = LK_SEND;
                  recv_phase_next = RP_IDLE;
                  send_phase_next = SP_ACK;
                  res_action      = A_ACK;
                  res_command     = hcmd;
                end else if (hlen != '0) begin
                  link_state_next = LK_RECV;
                  recv_phase_next = RP_DATA;
                  res_action      = A_RECV;
                  res_length      = hlen;
                end else begin
                  link_state_next = LK_IDLE;
                  send_phase_next = SP_IDLE;
                  recv_phase_next = RP_IDLE;
                  rx_command_next = '0;
                  rx_total_next   = '0;
                  res_action      = A_RCVD;
                  res_command     = hcmd;
                  res_code        = ev.completion_code;
                end
              end
              RP_DATA: begin
                res_valid = 1'b1;
                if (rx_total > pkt32) begin
                  link_state_next = LK_SEND;
                  recv_phase_next = RP_IDLE;
                  send_phase_next = SP_ACK;
                  res_action      = A_ACK;
                  res_command     = rx_command;
                end else begin
                  link_state_next = LK_IDLE;
                  send_phase_next = SP_IDLE;
                  recv_phase_next = RP_IDLE;
                  rx_command_next = '0;
                  rx_total_next   = '0;
                  res_action      = A_RCVD;
                  res_command     = rx_command;
                  res_code        = ev.completion_code;
                end
              end
              RP_ACK: begin
                res_valid = 1'b1;
                if (hcmd != tx_command) begin
                  send_phase_next = SP_IDLE;
                  recv_phase_next = RP_IDLE;
                  link_state_next = LK_IDLE;
                  res_action      = A_BADCMD;
                  res_command     = hcmd;
                end else begin
                  // next fragment never exceeds packet_size, so no initial header
                  link_state_next = LK_SEND;
                  recv_phase_next = RP_IDLE;
                  send_phase_next = SP_FHDR;
                  res_action      = A_HEADER;
                  res_command     = tx_command;
                  res_length      = frag;
                end
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_size    <= PACKET_SIZE_RST;
      resync_command <= '0;
      link_state     <= LK_IDLE;
      send_phase     <= SP_IDLE;
      recv_phase     <= RP_IDLE;
      tx_command     <= '0;
      tx_total       <= '0;
      tx_written     <= '0;
      rx_command     <= '0;
      rx_total       <= '0;
      act.valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PACKET_SIZE: packet_size    <= cfg_data[15:0];
          CFG_RESYNC_CMD:  resync_command <= cfg_data;
          default: ;
        endcase
      end
      link_state <= link_state_next;
      send_phase <= send_phase_next;
      recv_phase <= recv_phase_next;
      tx_command <= tx_command_next;
      tx_total   <= tx_total_next;
      tx_written <= tx_written_next;
      rx_command <= rx_command_next;
      rx_total   <= rx_total_next;
      if (act.ready) begin
        act.valid <= 1'b0;
      end
      if (res_valid) begin
        act.valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      act.action      <= res_action;
      act.out_command <= res_command;
      act.out_length  <= res_length;
      act.out_code    <= res_code;
    end
  end

  a_start_gives_header: assert property (@(posedge clk) disable iff (rst)
    accept && ev.opcode == OP_START |=> act.valid && act.action == A_HEADER)
    else $error("start send did not give a header");

  a_arm_posts_receive: assert property (@(posedge clk) disable iff (rst)
    accept && ev.opcode == OP_ARM |=> link_state == LK_RECV && recv_phase == RP_INIT)
    else $error("arm receive did not enter initial header receive");

  a_idle_send_silent: assert property (@(posedge clk) disable iff (rst)
    accept && ev.opcode == OP_SENT && send_phase == SP_IDLE
    |=> send_phase == SP_IDLE && $stable(tx_written))
    else $error("send completion while idle changed state");

  a_header_sets_send: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && (res_action == A_HEADER || res_action == A_ACK)
    |=> link_state == LK_SEND && recv_phase == RP_IDLE)
    else $error("header or ack sent outside send state");

endmodule
